// ----- rtl/ifsqrt_pkg.sv -----
// Shared constants for the integer floor square root block.
package ifsqrt_pkg;

	// Default width of the radicand.
	localparam int unsigned INPUT_BITS_DEF = 31;

	// Width of the root field on the result port.
	localparam int unsigned ROOT_BITS = 16;

endpackage

// ----- rtl/ifsqrt_cell.sv -----
// One digit cell of the square root chain: decides one root bit per pass.
module ifsqrt_cell #(
	parameter int unsigned CAND_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     valid_in,
	input  logic [2*CAND_BITS-1:0]   x_in,
	input  logic [CAND_BITS+1:0]     rem_in,
	input  logic [CAND_BITS-1:0]     root_in,
	output logic                     valid_s1,
	output logic [2*CAND_BITS-1:0]   x_s1,
	output logic [CAND_BITS+1:0]     rem_s1,
	output logic [CAND_BITS-1:0]     root_s1
);

	localparam int unsigned X_BITS   = 2 * CAND_BITS;
	localparam int unsigned REM_BITS = CAND_BITS + 2;

	logic [REM_BITS-1:0] rem_sh;
	logic [REM_BITS-1:0] trial;
	logic                ge;
	logic [REM_BITS-1:0] rem_next;
	logic [CAND_BITS-1:0] root_next;
	logic [X_BITS-1:0]   x_next;

	// Bring down the next two radicand bits and try the candidate 4*root+1.
	always_comb begin
		rem_sh    = {rem_in[REM_BITS-3:0], x_in[X_BITS-1 -: 2]};
		trial     = {root_in, 2'b01};
		ge        = (rem_sh >= trial);
		rem_next  = ge ? (rem_sh - trial) : rem_sh;
		root_next = CAND_BITS'({root_in, ge});
		x_next    = x_in << 2;
	end

	// Valid flag of this cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_in;
		end
	end

	// Working values handed to the next cell.
	always_ff @(posedge clk) begin
		if (en) begin
			x_s1    <= x_next;
			rem_s1  <= rem_next;
			root_s1 <= root_next;
		end
	end

endmodule

// ----- rtl/integer_floor_square_root.sv -----
// Throughput: one request per cycle unless a finished result is stalled; each cell of the chain settles one root bit.
// The whole chain advances together; it holds while a finished result is stalled.
// Reset clears every cell's valid flag; working values need no reset.
// The block is ready to take a request as soon as reset is released.
module integer_floor_square_root #(
	parameter int unsigned INPUT_BITS = ifsqrt_pkg::INPUT_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            radicand_valid,
	output logic                            radicand_stall,
	input  logic [INPUT_BITS-1:0]           radicand,
	output logic                            root_valid,
	input  logic                            root_stall,
	output logic [ifsqrt_pkg::ROOT_BITS-1:0] root
);

	localparam int unsigned CAND_BITS = (INPUT_BITS + 1) / 2;
	localparam int unsigned X_BITS    = 2 * CAND_BITS;
	localparam int unsigned REM_BITS  = CAND_BITS + 2;
	localparam int unsigned EXT_BITS  =
		(CAND_BITS > ifsqrt_pkg::ROOT_BITS) ? CAND_BITS : ifsqrt_pkg::ROOT_BITS;

	logic                 en;
	logic [CAND_BITS:0]   v_c;
	logic [X_BITS-1:0]    x_c    [CAND_BITS+1];
	logic [REM_BITS-1:0]  rem_c  [CAND_BITS+1];
	logic [CAND_BITS-1:0] root_c [CAND_BITS+1];
	logic [EXT_BITS-1:0]  root_ext;

	// The chain moves unless a finished result is waiting and stalled.
	assign en             = !root_valid || !root_stall;
	assign radicand_stall = !en;

	// Feed of the first cell.
	assign v_c[0]    = radicand_valid;
	assign x_c[0]    = X_BITS'(radicand);
	assign rem_c[0]  = '0;
	assign root_c[0] = '0;

	// Row of digit cells, most significant root bit first.
	for (genvar i = 0; i < CAND_BITS; i++) begin : g_cell
		ifsqrt_cell #(
			.CAND_BITS(CAND_BITS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.valid_in (v_c[i]),
			.x_in     (x_c[i]),
			.rem_in   (rem_c[i]),
			.root_in  (root_c[i]),
			.valid_s1 (v_c[i+1]),
			.x_s1     (x_c[i+1]),
			.rem_s1   (rem_c[i+1]),
			.root_s1  (root_c[i+1])
		);
	end

	// The last cell's registers form the result.
	assign root_valid = v_c[CAND_BITS];
	assign root_ext   = EXT_BITS'(root_c[CAND_BITS]);
	assign root       = root_ext[ifsqrt_pkg::ROOT_BITS-1:0];

	// A finished root leaves a remainder no larger than twice the root.
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		root_valid |-> (rem_c[CAND_BITS] <= REM_BITS'({root_c[CAND_BITS], 1'b0})))
		else $error("square root remainder out of range");

	// A stalled result freezes every cell's valid flag.
	a_chain_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(root_valid && root_stall) |=> $stable(v_c[CAND_BITS:1]))
		else $error("chain moved while the result was stalled");

	// An accepted request enters the first cell.
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(radicand_valid && !radicand_stall) |=> v_c[1])
		else $error("accepted request lost at the first cell");

	// While the chain moves, each cell takes its neighbor's valid flag.
	a_shift: assert property (@(posedge clk) disable iff (!arst_n)
		en |=> (v_c[CAND_BITS:1] == $past(v_c[CAND_BITS-1:0])))
		else $error("valid flags did not shift along the chain");

endmodule

// ----- verif/ifsqrt_root_scoreboard_pkg.sv -----
// Root predictor and scoreboard class for the integer floor square root testbench.
package ifsqrt_root_scoreboard_pkg;

	localparam int unsigned RADICAND_BITS = ifsqrt_pkg::INPUT_BITS_DEF;
	localparam int unsigned ROOT_BITS     = ifsqrt_pkg::ROOT_BITS;

	// One outstanding request and the root it should produce.
	typedef struct {
		logic [RADICAND_BITS-1:0] radicand;
		logic [ROOT_BITS-1:0]     root;
	} root_entry_t;

	// Settle one root bit per step, from the top bit down; a square equal to
	// the radicand is kept, so exact squares give their exact root.
	function automatic logic [ROOT_BITS-1:0] floor_sqrt(
		input logic [RADICAND_BITS-1:0] value
	);
		logic [63:0] root_acc;
		logic [63:0] trial;
		root_acc = '0;
		for (int b = (RADICAND_BITS + 1) / 2 - 1; b >= 0; b--) begin
			trial = root_acc | (64'd1 << b);
			if (trial * trial <= 64'(value)) begin
				root_acc = trial;
			end
		end
		return root_acc[ROOT_BITS-1:0];
	endfunction

	class root_scoreboard;
		root_entry_t pending_roots[$];
		int unsigned errors;

		function new();
			errors = 0;
		endfunction

		// Print one line for a failure and count it.
		task report(input string msg);
			$display("mismatch: %s", msg);
			errors++;
		endtask

		// An accepted request queues the root it must produce.
		task note_request(input logic [RADICAND_BITS-1:0] radicand);
			root_entry_t entry;
			entry.radicand = radicand;
			entry.root     = floor_sqrt(radicand);
			pending_roots.push_back(entry);
		endtask

		// An accepted result is matched against the oldest outstanding request.
		task check_root(input logic [ROOT_BITS-1:0] root);
			root_entry_t entry;
			if (pending_roots.size() == 0) begin
				report($sformatf("root %0d arrived with no request outstanding", root));
			end else begin
				entry = pending_roots.pop_front();
				if (root !== entry.root) begin
					report($sformatf("radicand %0d: root %0d, expected %0d",
						entry.radicand, root, entry.root));
				end
			end
		endtask

		function int unsigned outstanding();
			return pending_roots.size();
		endfunction

		// Any request still waiting at the end never got its result.
		task check_drained();
			while (pending_roots.size() != 0) begin
				report($sformatf("radicand %0d: no root returned", pending_roots[0].radicand));
				void'(pending_roots.pop_front());
			end
		endtask
	endclass

endpackage

// ----- verif/testbench.sv -----
// Testbench for the pipelined integer floor square root block.
module testbench;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned RADICAND_BITS    = ifsqrt_root_scoreboard_pkg::RADICAND_BITS;
	localparam int unsigned ROOT_BITS        = ifsqrt_pkg::ROOT_BITS;
	localparam int unsigned CYCLE_LIMIT      = 300000;
	localparam int unsigned REQUESTS_PER_PHASE = 530;
	localparam int unsigned DRAIN_CYCLES     = 40;
	localparam int unsigned LONG_HOLD_CYCLES = 300;
	localparam logic [63:0] RADICAND_MASK    = (64'd1 << RADICAND_BITS) - 64'd1;

	// Extremes, exact squares and their neighbors, and alternating bit patterns.
	localparam int unsigned DIRECTED_RADICANDS [23] = '{
		0, 1, 2, 3, 4, 5, 8, 9, 15, 16, 24, 25, 65535, 65536,
		715827882, 1073741823, 1073741824, 1431655765,
		2147302921, 2147395599, 2147395600, 2147395601, 2147483647
	};

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     radicand_valid = 1'b0;
	logic                     radicand_stall;
	logic [RADICAND_BITS-1:0] radicand = '0;
	logic                     root_valid;
	logic                     root_stall = 1'b0;
	logic [ROOT_BITS-1:0]     root;

	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	bit          long_hold = 1'b0;
	int unsigned cycle_count = 0;

	ifsqrt_root_scoreboard_pkg::root_scoreboard sb = new();

	integer_floor_square_root #(
		.INPUT_BITS(RADICAND_BITS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.radicand_valid(radicand_valid),
		.radicand_stall(radicand_stall),
		.radicand(radicand),
		.root_valid(root_valid),
		.root_stall(root_stall),
		.root(root)
	);

	// Clock generation.
	initial begin
		forever begin
			#5 clk = ~clk;
		end
	end

	// Reset is held from the start and released on a falling edge.
	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL integer_floor_square_root");
			$finish;
		end
	end

	// Both handshakes are observed at the rising edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (radicand_valid && !radicand_stall) begin
				sb.note_request(radicand);
			end
			if (root_valid && !root_stall) begin
				sb.check_root(root);
			end
		end
	end

	// Result side: random stalls, plus one long hold-off on request.
	initial begin
		forever begin
			@(negedge clk);
			if (long_hold) begin
				long_hold = 1'b0;
				root_stall <= 1'b1;
				repeat (LONG_HOLD_CYCLES) @(negedge clk);
			end
			root_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// Offer one request after random idle cycles and hold it until taken.
	task automatic send_request(input logic [RADICAND_BITS-1:0] value);
		while ($urandom_range(99) < send_idle_pct) begin
			radicand_valid <= 1'b0;
			@(negedge clk);
		end
		radicand_valid <= 1'b1;
		radicand <= value;
		forever begin
			@(posedge clk);
			if (!radicand_stall) break;
		end
		@(negedge clk);
	endtask

	// Random radicands, weighted toward exact squares and their neighbors.
	function automatic logic [RADICAND_BITS-1:0] next_radicand();
		logic [63:0] base;
		logic [63:0] value;
		case ($urandom_range(5))
			0: value = 64'($urandom);
			1: begin
				base  = 64'($urandom_range(46340, 0));
				value = base * base;
			end
			2: begin
				base  = 64'($urandom_range(46340, 1));
				value = base * base - 64'd1;
			end
			3: begin
				base  = 64'($urandom_range(46339, 0));
				value = base * base + 64'd2 * base;
			end
			4: value = 64'($urandom_range(1023, 0));
			default: value = 64'($urandom >> $urandom_range(31, 1));
		endcase
		return RADICAND_BITS'(value & RADICAND_MASK);
	endfunction

	// Main sequence: directed requests, two idling phases and a long-hold phase, drain and verdict.
	initial begin
		@(posedge arst_n);
		@(negedge clk);

		send_idle_pct = 38;
		recv_idle_pct = 58;
		foreach (DIRECTED_RADICANDS[i]) begin
			send_request(RADICAND_BITS'(DIRECTED_RADICANDS[i]));
		end

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 38;
					recv_idle_pct = 58;
				end
				1: begin
					send_idle_pct = 58;
					recv_idle_pct = 38;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
					// The sender keeps offering while results are held back.
					long_hold = 1'b1;
				end
			endcase
			repeat (REQUESTS_PER_PHASE) send_request(next_radicand());
		end
		radicand_valid <= 1'b0;

		while (sb.outstanding() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		sb.check_drained();

		if (sb.errors == 0) begin
			$display("PASS integer_floor_square_root");
		end else begin
			$display("FAIL integer_floor_square_root");
		end
		$finish;
	end

endmodule

// ----- integer_floor_square_root.f -----
rtl/ifsqrt_pkg.sv
rtl/ifsqrt_cell.sv
rtl/integer_floor_square_root.sv
verif/ifsqrt_root_scoreboard_pkg.sv
verif/testbench.sv
